### rtl/core/dsi_hblank_lane_alignment_defines.svh
// Assertion helpers for the horizontal blanking lane alignment block.
`ifndef DSI_HBLANK_LANE_ALIGNMENT_DEFINES_SVH
`define DSI_HBLANK_LANE_ALIGNMENT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define DSI_HBLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DSI_HBLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DSI_HBLA_ASSERT(lbl, prop, msg)
`define DSI_HBLA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/dsi_hbla_pkg.sv
package dsi_hbla_pkg;

  localparam int unsigned BPP_W      = 6;
  localparam int unsigned LANE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANES = 2'd1;

  localparam logic [BPP_W-1:0]  BPP_RESET   = 6'd24;
  localparam logic [LANE_W-1:0] LANES_RESET = 3'd4;

  // Control from the top level into the sequencer.
  typedef struct packed {
    logic start;  // item transfer, latch operands
    logic take;   // result moved into the output register
  } hbla_ctl_t;

  // Status from the sequencer.
  typedef struct packed {
    logic busy;   // an item is in progress or waiting to leave
    logic done;   // result valid on the result ports
  } hbla_stat_t;

endpackage

### rtl/core/dsi_hblank_lane_alignment.sv
// Horizontal blanking lane alignment for a DSI host.
// Input channel (in_valid_i/in_ready_o) carries one horizontal timing: active
// width, front porch, sync width and back porch. Output channel
// (out_valid_o/out_ready_i) returns the three blanking widths, raised where
// needed so that width times bits per pixel fills whole lane bytes, plus a
// flag that tells whether the alignment tests called for an adjustment.
// Configuration port (cfg_valid_i/cfg_ready_o, always ready) writes bits per
// pixel at index 0 and lane count at index 1; write only while idle.
// Operation: one shared modular adder walks each operand bit by bit, TB+2
// bits per residue (TB = TIMING_BITS). Bits per pixel plus three tests make
// four residues; an adjusted item adds three more residues plus a search over
// up to 8*lanes candidate amounts per component, and the result then moves
// into the output register.
// One item is in work at a time; a new item is taken once the previous result
// has moved to the output register, even while that result waits there.
// Reset: bits per pixel 24, lane count 4, both channels empty.
// Receiver stall: the result holds in the output register, and a finished
// item holds in the sequencer until the register frees up.
`include "dsi_hblank_lane_alignment_defines.svh"

module dsi_hblank_lane_alignment #(
  parameter int unsigned MAX_LANES   = 4,
  parameter int unsigned TIMING_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dsi_hbla_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dsi_hbla_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TIMING_BITS-1:0]              active_width_i,
  input  logic [TIMING_BITS-1:0]              front_porch_i,
  input  logic [TIMING_BITS-1:0]              sync_width_i,
  input  logic [TIMING_BITS-1:0]              back_porch_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [TIMING_BITS:0]                adjusted_front_porch_o,
  output logic [TIMING_BITS:0]                adjusted_sync_width_o,
  output logic [TIMING_BITS:0]                adjusted_back_porch_o,
  output logic                                was_adjusted_o
);
  import dsi_hbla_pkg::*;

  // Lane count field and divisor (eight bits per lane) widths.
  localparam int unsigned LW = $clog2(MAX_LANES + 1);
  localparam int unsigned DW = LW + 3;

  logic [BPP_W-1:0]  bpp_q;
  logic [LANE_W-1:0] lanes_q;
  logic [LW-1:0]     lanes_eff;
  logic [DW-1:0]     div;

  hbla_ctl_t  ctl;
  hbla_stat_t stat;

  logic [TIMING_BITS:0] seq_hfp, seq_hsa, seq_hbp;
  logic                 seq_fix;

  logic                 out_valid_q;
  logic [TIMING_BITS:0] out_hfp_q, out_hsa_q, out_hbp_q;
  logic                 out_fix_q;

  // Configuration registers; every transfer completes at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      lanes_q <= LANES_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BPP:   bpp_q   <= cfg_data_i[BPP_W-1:0];
        CFG_LANES: lanes_q <= cfg_data_i[LANE_W-1:0];
        default:   ;  // drop writes to unused indexes
      endcase
    end
  end

  // Zero lanes counts as one, anything above the maximum saturates.
  always_comb begin
    if (lanes_q == '0) begin
      lanes_eff = LW'(1);
    end else if (32'(lanes_q) > MAX_LANES) begin
      lanes_eff = LW'(MAX_LANES);
    end else begin
      lanes_eff = LW'(lanes_q);
    end
    div = {lanes_eff, 3'b000};
  end

  // Accept while the sequencer is idle; advance a finished result whenever
  // the output register is empty or being drained this cycle.
  assign in_ready_o = !stat.busy;
  assign ctl.start  = in_valid_i && in_ready_o;
  assign ctl.take   = stat.done && (!out_valid_q || out_ready_i);

  dsi_hbla_seq #(
    .TIMING_BITS(TIMING_BITS),
    .DW         (DW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .bpp_i    (bpp_q),
    .div_i    (div),
    .act_i    (active_width_i),
    .hfp_i    (front_porch_i),
    .hsa_i    (sync_width_i),
    .hbp_i    (back_porch_i),
    .adj_hfp_o(seq_hfp),
    .adj_hsa_o(seq_hsa),
    .adj_hbp_o(seq_hbp),
    .fix_o    (seq_fix)
  );

  // Output register: hold the result until the receiver takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      out_hfp_q <= seq_hfp;
      out_hsa_q <= seq_hsa;
      out_hbp_q <= seq_hbp;
      out_fix_q <= seq_fix;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign adjusted_front_porch_o = out_hfp_q;
  assign adjusted_sync_width_o  = out_hsa_q;
  assign adjusted_back_porch_o  = out_hbp_q;
  assign was_adjusted_o         = out_fix_q;

  // An accepted item keeps the input side closed on the next cycle.
  `DSI_HBLA_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "input not closed after transfer")
  // A finished result stays finished while the output register is stalled.
  `DSI_HBLA_ASSERT(a_done_holds, stat.done && out_valid_o && !out_ready_i |=> stat.done, "finished result lost under stall")
  // A bits-per-pixel write lands in its register.
  `DSI_HBLA_ASSERT(a_cfg_bpp, cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_BPP) |=> bpp_q == $past(cfg_data_i), "bits per pixel write missed")
  // The sequencer never reports done without being busy, reset included.
  `DSI_HBLA_ASSERT_ALWAYS(a_done_busy, stat.done |-> stat.busy, "done without busy")

endmodule

### rtl/core/dsi_hbla_modadd.sv
module dsi_hbla_modadd #(
  parameter int unsigned DW = 6
) (
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic [DW-1:0] c_i,
  input  logic [DW-1:0] div_i,
  output logic [DW-1:0] y_o
);

  // Operands are all below the divisor, so the sum stays below three times it.
  logic [DW+1:0] sum;
  logic [DW+1:0] div1;
  logic [DW+1:0] div2;

  always_comb begin
    sum  = (DW+2)'(a_i) + (DW+2)'(b_i) + (DW+2)'(c_i);
    div1 = (DW+2)'(div_i);
    div2 = div1 << 1;
    if (sum >= div2) begin
      y_o = DW'(sum - div2);
    end else if (sum >= div1) begin
      y_o = DW'(sum - div1);
    end else begin
      y_o = DW'(sum);
    end
  end

endmodule

### rtl/core/dsi_hbla_seq.sv
module dsi_hbla_seq #(
  parameter int unsigned TIMING_BITS = 13,
  parameter int unsigned DW          = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dsi_hbla_pkg::hbla_ctl_t          ctl_i,
  output dsi_hbla_pkg::hbla_stat_t         stat_o,
  input  logic [dsi_hbla_pkg::BPP_W-1:0]   bpp_i,
  input  logic [DW-1:0]                    div_i,
  input  logic [TIMING_BITS-1:0]           act_i,
  input  logic [TIMING_BITS-1:0]           hfp_i,
  input  logic [TIMING_BITS-1:0]           hsa_i,
  input  logic [TIMING_BITS-1:0]           hbp_i,
  output logic [TIMING_BITS:0]             adj_hfp_o,
  output logic [TIMING_BITS:0]             adj_hsa_o,
  output logic [TIMING_BITS:0]             adj_hbp_o,
  output logic                             fix_o
);
  import dsi_hbla_pkg::*;

  localparam int unsigned TW = TIMING_BITS + 2;  // total width needs two extra bits
  localparam int unsigned OW = TIMING_BITS + 1;
  localparam int unsigned CW = $clog2(TW);

  // Operand order; the sequencer advances only to the next code, or finishes.
  localparam logic [2:0] OP_BPP = 3'd0;
  localparam logic [2:0] OP_TOT = 3'd1;
  localparam logic [2:0] OP_HSA = 3'd2;
  localparam logic [2:0] OP_HBP = 3'd3;
  localparam logic [2:0] OP_FFP = 3'd4;
  localparam logic [2:0] OP_FSA = 3'd5;
  localparam logic [2:0] OP_FBP = 3'd6;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [2:0]             op_q, op_d;
  logic [TW-1:0]          x_q, x_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [DW-1:0]          r_q, r_d;
  logic [DW-1:0]          bppm_q, bppm_d;
  logic [DW-1:0]          i_q, i_d;
  logic                   fail_q, fail_d;
  logic                   fix_q, fix_d;
  logic [TW-1:0]          tot_q, tot_d;
  logic [TIMING_BITS-1:0] hfp_q, hfp_d;
  logic [TIMING_BITS-1:0] hsa_q, hsa_d;
  logic [TIMING_BITS-1:0] hbp_q, hbp_d;
  logic [OW-1:0]          adj_q [3];
  logic [OW-1:0]          adj_d [3];

  logic [2:0]             op_nxt;
  logic [TW-1:0]          x_nxt;
  logic [TIMING_BITS-1:0] base;
  logic [1:0]             sel;
  logic [DW-1:0]          ua, ub, uc, uy;
  logic [DW-1:0]          kval;

  // Shared modular adder: residue doubling steps and search steps.
  dsi_hbla_modadd #(.DW(DW)) u_modadd (
    .a_i  (ua),
    .b_i  (ub),
    .c_i  (uc),
    .div_i(div_i),
    .y_o  (uy)
  );

  always_comb begin
    kval = (op_q == OP_BPP) ? DW'(1) : bppm_q;
    ua   = r_q;
    ub   = (state_q == S_SRCH) ? bppm_q : r_q;
    uc   = (state_q == S_RES && x_q[TW-1]) ? kval : '0;
  end

  always_comb begin
    op_nxt = op_q + 3'd1;
    case (op_nxt)
      OP_TOT:  x_nxt = tot_q;
      OP_HSA:  x_nxt = TW'(hsa_q);
      OP_HBP:  x_nxt = TW'(hbp_q);
      OP_FFP:  x_nxt = TW'(hfp_q);
      OP_FSA:  x_nxt = TW'(hsa_q);
      OP_FBP:  x_nxt = TW'(hbp_q);
      default: x_nxt = '0;
    endcase
    sel = 2'(op_q - OP_FFP);
    case (op_q)
      OP_FFP:  base = hfp_q;
      OP_FSA:  base = hsa_q;
      default: base = hbp_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    x_d     = x_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    bppm_d  = bppm_q;
    i_d     = i_q;
    fail_d  = fail_q;
    fix_d   = fix_q;
    tot_d   = tot_q;
    hfp_d   = hfp_q;
    hsa_d   = hsa_q;
    hbp_d   = hbp_q;
    adj_d   = adj_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          hfp_d    = hfp_i;
          hsa_d    = hsa_i;
          hbp_d    = hbp_i;
          tot_d    = TW'(act_i) + TW'(hfp_i) + TW'(hsa_i) + TW'(hbp_i);
          adj_d[0] = OW'(hfp_i);
          adj_d[1] = OW'(hsa_i);
          adj_d[2] = OW'(hbp_i);
          x_d      = TW'(bpp_i);
          cnt_d    = '0;
          r_d      = '0;
          op_d     = OP_BPP;
          fail_d   = 1'b0;
          fix_d    = 1'b0;
          state_d  = S_RES;
        end
      end
      S_RES: begin
        r_d   = uy;
        x_d   = x_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(TW - 1)) begin
          cnt_d = '0;
          case (op_q)
            OP_BPP: begin
              bppm_d = uy;
              op_d   = op_nxt;
              x_d    = x_nxt;
              r_d    = '0;
            end
            OP_TOT, OP_HSA: begin
              fail_d = fail_q | (uy != '0);
              op_d   = op_nxt;
              x_d    = x_nxt;
              r_d    = '0;
            end
            OP_HBP: begin
              if (fail_q || uy != '0) begin
                fix_d = 1'b1;
                op_d  = op_nxt;
                x_d   = x_nxt;
                r_d   = '0;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              i_d     = '0;
              state_d = S_SRCH;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (r_q == '0 || i_q == div_i - DW'(1)) begin
          if (r_q == '0) begin
            adj_d[sel] = OW'(base) + OW'(i_q);
          end
          if (op_q == OP_FBP) begin
            state_d = S_DONE;
          end else begin
            op_d    = op_nxt;
            x_d     = x_nxt;
            r_d     = '0;
            cnt_d   = '0;
            state_d = S_RES;
          end
        end else begin
          r_d = uy;
          i_d = i_q + DW'(1);
        end
      end
      S_DONE: begin
        if (ctl_i.take) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_BPP;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
      fix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      fix_q   <= fix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    bppm_q <= bppm_d;
    i_q    <= i_d;
    tot_q  <= tot_d;
    hfp_q  <= hfp_d;
    hsa_q  <= hsa_d;
    hbp_q  <= hbp_d;
    adj_q  <= adj_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign adj_hfp_o   = adj_q[0];
  assign adj_hsa_o   = adj_q[1];
  assign adj_hbp_o   = adj_q[2];
  assign fix_o       = fix_q;

endmodule
